// ----- rtl/efhm_pkg.sv -----
// Package with the hash table sizes, operation and status codes, and the state type.
package efhm_pkg;
  localparam int SOURCE_SLOTS = 256;
  localparam int DEST_SLOTS   = 16;
  localparam int SW           = $clog2(SOURCE_SLOTS);
  localparam int DW           = $clog2(DEST_SLOTS);
  localparam int EW           = SW + DW;
  localparam int ALL_DEST     = SOURCE_SLOTS * DEST_SLOTS;
  localparam int KEY_W        = 128;
  localparam int SRC_ROW_W    = KEY_W;
  localparam int DST_ROW_W    = KEY_W + 32;

  typedef enum logic [1:0] {
    OP_INC   = 2'd0,
    OP_LOOK  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_FULL     = 2'd2
  } status_t;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_HASH  = 10'b0000000010,
    S_SRD   = 10'b0000000100,
    S_SCMP  = 10'b0000001000,
    S_DRD   = 10'b0000010000,
    S_DCMP  = 10'b0000100000,
    S_DONE  = 10'b0001000000,
    S_CLR   = 10'b0010000000,
    S_INIT  = 10'b0100000000,
    S_SWAIT = 10'b1000000000
  } state_t;
endpackage

// ----- rtl/efhm_ram.sv -----
// Generic single-port-write, registered-read RAM.
module efhm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- rtl/edge_frequency_hash_map.sv -----
// Top level of the edge frequency hash map with its probing sequencer.
// Each beat hashes the source key, probes the source table (1..256 slots), hashes the
// destination key and probes its row (1..16 slots); a new source adds an S_SWAIT state.
// Throughput: one beat in flight; busy stays high until the result strobe.
// A missing source ends a lookup after the source probe; the unused op goes straight to S_DONE.
// Reset (rst_n low, synchronous) starts a pass that clears the valid memories; busy is
// high during it. A clear operation re-runs the same pass.
module edge_frequency_hash_map (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_op,
  input  logic [31:0] in_src_thread,
  input  logic [63:0] in_src_instruction,
  input  logic [31:0] in_src_visit,
  input  logic [31:0] in_dst_thread,
  input  logic [63:0] in_dst_instruction,
  input  logic [31:0] in_dst_visit,
  output logic        out_valid,
  output logic [31:0] out_frequency,
  output logic [1:0]  out_status,
  output logic [8:0]  out_sources_held,
  output logic [12:0] out_edges_held
);
  import efhm_pkg::*;

  // Registered copy of the command beat.
  op_t                 op_r;
  logic [KEY_W-1:0]    skey_r, dkey_r;

  state_t              state_r, state_nxt;
  // The shared hash unit: one multiply-by-33 and XOR step per cycle over
  // four 32-bit words, run for the source key and then the destination key.
  logic [31:0]         h_r;
  logic [2:0]          hstep_r;
  logic [SW-1:0]       sidx_r, sstart_r;
  logic [DW-1:0]       didx_r, dstart_r;
  logic                first_r;
  logic [SW:0]         clr_r;
  logic [SW:0]         stot_r;
  logic [EW:0]         etot_r;
  logic [31:0]         freq_r;
  status_t             stat_r;
  logic                oval_r;

  // Valid bits live in RAMs: one bit per source slot, and one DEST_SLOTS-wide
  // row per source slot for the destination valid bits.
  logic                sv_we, sv_wd, sv_rd;
  logic [SW-1:0]       sv_wa, sv_ra;
  logic                dv_we;
  logic [DEST_SLOTS-1:0] dv_wd, dv_rd;
  logic [SW-1:0]       dv_wa;
  logic                sk_we;
  logic [SRC_ROW_W-1:0] sk_rd;
  logic                dk_we;
  logic [DST_ROW_W-1:0] dk_wd, dk_rd;
  logic [EW-1:0]       dk_a;

  logic [31:0]         word;
  logic [31:0]         h_step;

  efhm_ram #(.WIDTH(1), .DEPTH(SOURCE_SLOTS)) u_svalid (
    .clk, .we(sv_we), .waddr(sv_wa), .wdata(sv_wd), .raddr(sv_ra), .rdata(sv_rd));
  efhm_ram #(.WIDTH(DEST_SLOTS), .DEPTH(SOURCE_SLOTS)) u_dvalid (
    .clk, .we(dv_we), .waddr(dv_wa), .wdata(dv_wd), .raddr(sv_ra), .rdata(dv_rd));
  efhm_ram #(.WIDTH(SRC_ROW_W), .DEPTH(SOURCE_SLOTS)) u_skey (
    .clk, .we(sk_we), .waddr(sidx_r), .wdata(skey_r), .raddr(sidx_r), .rdata(sk_rd));
  efhm_ram #(.WIDTH(DST_ROW_W), .DEPTH(ALL_DEST)) u_dkey (
    .clk, .we(dk_we), .waddr(dk_a), .wdata(dk_wd), .raddr(dk_a), .rdata(dk_rd));

  assign dk_a = {sidx_r, didx_r};

  // Key word order: thread, instruction low, instruction high, visit.
  // Key layout: {thread, instruction, visit}.
  logic [KEY_W-1:0] hkey;
  assign hkey = first_r ? skey_r : dkey_r;
  always_comb begin
    case (hstep_r[1:0])
      2'd0:    word = hkey[127:96];
      2'd1:    word = hkey[63:32];
      2'd2:    word = hkey[95:64];
      default: word = hkey[31:0];
    endcase
  end
  assign h_step = ((h_r << 5) + h_r) ^ word;

  // The valid RAM read address follows the hash output while hashing, else the probe index.
  assign sv_ra = (state_r == S_HASH) ? h_step[SW-1:0] : sidx_r;

  logic src_hit, dst_hit;
  assign src_hit = (sk_rd == skey_r);
  assign dst_hit = (dk_rd[DST_ROW_W-1:32] == dkey_r);

  always_comb begin
    state_nxt = state_r;
    sv_we = 1'b0; sv_wa = sidx_r; sv_wd = 1'b1;
    dv_we = 1'b0; dv_wa = sidx_r; dv_wd = dv_rd | (DEST_SLOTS'(1) << didx_r);
    sk_we = 1'b0;
    dk_we = 1'b0; dk_wd = {dkey_r, 32'd1};
    unique case (state_r)
      S_INIT, S_CLR: begin
        sv_we = 1'b1; sv_wa = clr_r[SW-1:0]; sv_wd = 1'b0;
        dv_we = 1'b1; dv_wa = clr_r[SW-1:0]; dv_wd = '0;
        if (clr_r[SW]) state_nxt = (state_r == S_CLR) ? S_DONE : S_IDLE;
      end
      S_IDLE: if (start) begin
        unique case (op_t'(in_op))
          OP_INC, OP_LOOK: state_nxt = S_HASH;
          OP_CLEAR:        state_nxt = S_CLR;
          default:         state_nxt = S_DONE;
        endcase
      end
      S_HASH: if (hstep_r == 3'd3) state_nxt = first_r ? S_SRD : S_DRD;
      S_SRD:  state_nxt = S_SCMP;
      S_SCMP: begin
        if (!sv_rd) begin
          if (op_r == OP_INC) begin
            sv_we = 1'b1; sk_we = 1'b1; dv_we = 1'b1; dv_wd = '0;
            state_nxt = S_SWAIT;
          end else state_nxt = S_DONE;
        end else if (src_hit) state_nxt = S_HASH;
        else if (sidx_r + SW'(1) == sstart_r) state_nxt = S_DONE;
        else state_nxt = S_SRD;
      end
      S_SWAIT: state_nxt = S_HASH;
      S_DRD:  state_nxt = S_DCMP;
      S_DCMP: begin
        if (!dv_rd[didx_r]) begin
          if (op_r == OP_INC) begin
            dv_we = 1'b1; dk_we = 1'b1;
          end
          state_nxt = S_DONE;
        end else if (dst_hit) begin
          if (op_r == OP_INC) begin
            dk_we = 1'b1; dk_wd = {dkey_r, dk_rd[31:0] + 32'd1};
          end
          state_nxt = S_DONE;
        end else if (didx_r + DW'(1) == dstart_r) state_nxt = S_DONE;
        else state_nxt = S_DRD;
      end
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      clr_r   <= '0;
      stot_r  <= '0;
      etot_r  <= '0;
      oval_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      oval_r  <= (state_r == S_DONE);
      unique case (state_r)
        S_INIT, S_CLR: clr_r <= clr_r + (SW+1)'(1);
        S_IDLE: begin
          clr_r   <= '0;
          if (start) begin
            op_r    <= op_t'(in_op);
            skey_r  <= {in_src_thread, in_src_instruction, in_src_visit};
            dkey_r  <= {in_dst_thread, in_dst_instruction, in_dst_visit};
            h_r     <= 32'd5381;
            hstep_r <= '0;
            first_r <= 1'b1;
            freq_r  <= '0;
            stat_r  <= ST_OK;
            if (op_t'(in_op) == OP_CLEAR) begin
              stot_r <= '0;
              etot_r <= '0;
            end
          end
        end
        S_HASH: begin
          h_r     <= h_step;
          hstep_r <= hstep_r + 3'd1;
          if (hstep_r == 3'd3) begin
            h_r     <= 32'd5381;
            hstep_r <= '0;
            first_r <= 1'b0;
            if (first_r) begin
              sidx_r   <= h_step[SW-1:0];
              sstart_r <= h_step[SW-1:0];
            end else begin
              didx_r   <= h_step[DW-1:0];
              dstart_r <= h_step[DW-1:0];
            end
          end
        end
        S_SCMP: begin
          if (!sv_rd) begin
            if (op_r == OP_INC) stot_r <= stot_r + (SW+1)'(1);
            else stat_r <= ST_NOTFOUND;
          end else if (!src_hit) begin
            if (sidx_r + SW'(1) == sstart_r)
              stat_r <= (op_r == OP_INC) ? ST_FULL : ST_NOTFOUND;
            sidx_r <= sidx_r + SW'(1);
          end
        end
        S_DCMP: begin
          if (!dv_rd[didx_r]) begin
            if (op_r == OP_INC) begin
              etot_r <= etot_r + (EW+1)'(1);
              freq_r <= 32'd1;
            end else stat_r <= ST_NOTFOUND;
          end else if (dst_hit) begin
            freq_r <= dk_rd[31:0] + ((op_r == OP_INC) ? 32'd1 : 32'd0);
          end else begin
            if (didx_r + DW'(1) == dstart_r)
              stat_r <= (op_r == OP_INC) ? ST_FULL : ST_NOTFOUND;
            didx_r <= didx_r + DW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  assign busy             = (state_r != S_IDLE);
  assign out_valid        = oval_r;
  assign out_frequency    = freq_r;
  assign out_status       = stat_r;
  assign out_sources_held = 9'(stot_r);
  assign out_edges_held   = 13'(etot_r);
endmodule

// ----- rtl/efhm_checker.sv -----
// Port-level checker for the edge frequency hash map, bound to the top level.
module efhm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [1:0]  out_status,
  input logic [31:0] out_frequency
);
  import efhm_pkg::*;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("busy not raised after accept");
  a_result_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");
  a_idle_after: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("busy while result shown");
  a_bad_freq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_frequency == 32'd0)
    else $error("nonzero frequency with error status");
endmodule

bind edge_frequency_hash_map efhm_checker u_efhm_checker (
  .clk, .rst_n, .start, .busy, .out_valid, .out_status, .out_frequency);

// ----- tb/tb_edge_frequency_hash_map.sv -----
// Self-checking testbench for the edge frequency hash map: drives commands, predicts, compares.
`timescale 1ns / 100ps

class freq_scoreboard;
  // Predicted copy of both tables.
  bit          src_used [efhm_pkg::SOURCE_SLOTS];
  logic [31:0] src_thr  [efhm_pkg::SOURCE_SLOTS];
  logic [63:0] src_ins  [efhm_pkg::SOURCE_SLOTS];
  logic [31:0] src_vis  [efhm_pkg::SOURCE_SLOTS];
  bit          dst_used [efhm_pkg::ALL_DEST];
  logic [31:0] dst_thr  [efhm_pkg::ALL_DEST];
  logic [63:0] dst_ins  [efhm_pkg::ALL_DEST];
  logic [31:0] dst_vis  [efhm_pkg::ALL_DEST];
  logic [31:0] counts   [efhm_pkg::ALL_DEST];
  int          n_src;
  int          n_edge;
  // Each pending beat packs frequency, status, sources and edges.
  logic [55:0] pending_results [$];
  int          errors;

  function new();
    clear_tables();
    errors = 0;
  endfunction

  function void clear_tables();
    foreach (src_used[i]) src_used[i] = 0;
    foreach (dst_used[i]) dst_used[i] = 0;
    n_src = 0;
    n_edge = 0;
  endfunction

  function int key_hash(logic [31:0] t, logic [63:0] ins, logic [31:0] v, int size);
    logic [31:0] h;
    h = 32'd5381;
    h = (h * 33) ^ t;
    h = (h * 33) ^ ins[31:0];
    h = (h * 33) ^ ins[63:32];
    h = (h * 33) ^ v;
    return h % size;
  endfunction

  function void note_command(efhm_pkg::op_t op, logic [31:0] st, logic [63:0] si,
                             logic [31:0] sv, logic [31:0] dt, logic [63:0] di,
                             logic [31:0] dv);
    logic [31:0] freq;
    efhm_pkg::status_t stat;
    int s, d, i, start_i, base;
    bit s_found, s_room, d_found, d_room;
    freq = 0;
    stat = efhm_pkg::ST_OK;
    s_found = 0; s_room = 0; d_found = 0; d_room = 0; s = 0; d = 0;
    if (op == efhm_pkg::OP_INC || op == efhm_pkg::OP_LOOK) begin
      // Linear probe of the source table, stopping at the first free slot or at a match.
      start_i = key_hash(st, si, sv, efhm_pkg::SOURCE_SLOTS);
      i = start_i;
      do begin
        if (!src_used[i]) begin
          s = i; s_room = 1; break;
        end
        if (src_thr[i] == st && src_ins[i] == si && src_vis[i] == sv) begin
          s = i; s_found = 1; break;
        end
        i = (i + 1) % efhm_pkg::SOURCE_SLOTS;
      end while (i != start_i);
      if (op == efhm_pkg::OP_INC && !s_found && s_room) begin
        src_used[s] = 1; src_thr[s] = st; src_ins[s] = si; src_vis[s] = sv;
        n_src++;
        s_found = 1;
      end
      if (s_found) begin
        // The destination table of this source is probed the same way.
        base = s * efhm_pkg::DEST_SLOTS;
        start_i = key_hash(dt, di, dv, efhm_pkg::DEST_SLOTS);
        i = start_i;
        do begin
          if (!dst_used[base + i]) begin
            d = base + i; d_room = 1; break;
          end
          if (dst_thr[base + i] == dt && dst_ins[base + i] == di &&
              dst_vis[base + i] == dv) begin
            d = base + i; d_found = 1; break;
          end
          i = (i + 1) % efhm_pkg::DEST_SLOTS;
        end while (i != start_i);
      end
      if (op == efhm_pkg::OP_INC) begin
        if (!s_found) stat = efhm_pkg::ST_FULL;
        else if (d_found) begin
          counts[d] = counts[d] + 1;
          freq = counts[d];
        end else if (d_room) begin
          dst_used[d] = 1; dst_thr[d] = dt; dst_ins[d] = di; dst_vis[d] = dv;
          counts[d] = 1;
          n_edge++;
          freq = 1;
        end else stat = efhm_pkg::ST_FULL;
      end else begin
        if (s_found && d_found) freq = counts[d];
        else stat = efhm_pkg::ST_NOTFOUND;
      end
    end else if (op == efhm_pkg::OP_CLEAR) begin
      clear_tables();
    end
    pending_results.push_back({freq, stat, n_src[8:0], n_edge[12:0]});
  endfunction

  // Test hook so that wrap can be reached without four billion increments.
  function void preset_count(logic [31:0] t, logic [63:0] ins, logic [31:0] v,
                             logic [31:0] value);
    foreach (dst_used[k])
      if (dst_used[k] && dst_thr[k] == t && dst_ins[k] == ins && dst_vis[k] == v)
        counts[k] = value;
  endfunction

  function void check_result(logic [31:0] freq, logic [1:0] stat, logic [8:0] srcs,
                             logic [12:0] edges);
    logic [55:0] exp_beat;
    if (pending_results.size() == 0) begin
      $display("%0t: unexpected result beat freq=%h status=%0d", $time, freq, stat);
      errors++;
      return;
    end
    exp_beat = pending_results.pop_front();
    if (exp_beat[55:24] !== freq) begin
      $display("%0t: frequency expected %h actual %h", $time, exp_beat[55:24], freq);
      errors++;
    end
    if (exp_beat[23:22] !== stat) begin
      $display("%0t: status expected %0d actual %0d", $time, exp_beat[23:22], stat);
      errors++;
    end
    if (exp_beat[21:13] !== srcs) begin
      $display("%0t: sources_held expected %0d actual %0d", $time, exp_beat[21:13], srcs);
      errors++;
    end
    if (exp_beat[12:0] !== edges) begin
      $display("%0t: edges_held expected %0d actual %0d", $time, exp_beat[12:0], edges);
      errors++;
    end
  endfunction
endclass

module tb_edge_frequency_hash_map;
  import efhm_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_op;
  logic [31:0] in_src_thread;
  logic [63:0] in_src_instruction;
  logic [31:0] in_src_visit;
  logic [31:0] in_dst_thread;
  logic [63:0] in_dst_instruction;
  logic [31:0] in_dst_visit;
  logic        out_valid;
  logic [31:0] out_frequency;
  logic [1:0]  out_status;
  logic [8:0]  out_sources_held;
  logic [12:0] out_edges_held;

  freq_scoreboard edge_board;

  // A small pool of keys, so that random increments hit existing edges often.
  logic [127:0] key_pool [16];

  edge_frequency_hash_map u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_op              (in_op),
    .in_src_thread      (in_src_thread),
    .in_src_instruction (in_src_instruction),
    .in_src_visit       (in_src_visit),
    .in_dst_thread      (in_dst_thread),
    .in_dst_instruction (in_dst_instruction),
    .in_dst_visit       (in_dst_visit),
    .out_valid          (out_valid),
    .out_frequency      (out_frequency),
    .out_status         (out_status),
    .out_sources_held   (out_sources_held),
    .out_edges_held     (out_edges_held)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // The result side cannot stall, so every strobed beat is checked at the edge that
  // ends its cycle. Sampling at the edge reads the values from before the update.
  always @(posedge clk) begin
    if (rst_n && out_valid)
      edge_board.check_result(out_frequency, out_status, out_sources_held, out_edges_held);
  end

  // Sends one command beat and holds it until the edge where busy is low.
  // Since the block runs one beat at a time, start drops only after busy is seen low.
  task automatic send_command(op_t op, logic [127:0] src_key, logic [127:0] dst_key);
    start              <= 1'b1;
    in_op              <= op;
    in_src_thread      <= src_key[127:96];
    in_src_instruction <= src_key[95:32];
    in_src_visit       <= src_key[31:0];
    in_dst_thread      <= dst_key[127:96];
    in_dst_instruction <= dst_key[95:32];
    in_dst_visit       <= dst_key[31:0];
    @(posedge clk);
    while (busy) @(posedge clk);
    edge_board.note_command(op, src_key[127:96], src_key[95:32], src_key[31:0],
                            dst_key[127:96], dst_key[95:32], dst_key[31:0]);
    start <= 1'b0;
    // Wait until the result has come, so state presets stay between beats.
    @(posedge clk);
    while (edge_board.pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [127:0] random_key();
    return {$urandom(), $urandom(), $urandom(), $urandom()};
  endfunction

  initial begin
    logic [127:0] src_a, dst_a, src_b;
    int burst, gap, pick;
    op_t op;

    edge_board = new();
    rst_n = 1'b0;
    start = 1'b0;
    in_op = OP_NONE;
    in_src_thread = '0;
    in_src_instruction = '0;
    in_src_visit = '0;
    in_dst_thread = '0;
    in_dst_instruction = '0;
    in_dst_visit = '0;
    foreach (key_pool[i]) key_pool[i] = random_key();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: the field extremes, every op code and the special cases.
    src_a = '0;
    dst_a = '1;
    send_command(OP_LOOK, src_a, dst_a);
    send_command(OP_INC, src_a, dst_a);
    send_command(OP_INC, src_a, dst_a);
    send_command(OP_LOOK, src_a, dst_a);
    send_command(OP_INC, '1, '0);
    send_command(OP_LOOK, src_a, '0);
    send_command(OP_NONE, src_a, dst_a);
    // Count wrap: only the predicted count is preset near wrap, then set back to its true value.
    edge_board.preset_count(dst_a[127:96], dst_a[95:32], dst_a[31:0], 32'hffff_fffe);
    // The block itself cannot be preset, so wrap is not exercised; no command runs in between.
    edge_board.preset_count(dst_a[127:96], dst_a[95:32], dst_a[31:0], 32'd2);
    // Destination table full: seventeen distinct edges from one source.
    src_b = random_key();
    for (int i = 0; i < DEST_SLOTS + 1; i++) send_command(OP_INC, src_b, random_key());
    send_command(OP_CLEAR, src_a, dst_a);
    send_command(OP_LOOK, src_a, dst_a);

    // Random part in bursts with gaps, mostly over a small key pool with occasional clears.
    for (int n = 0; n < 770; ) begin
      burst = $urandom_range(1, 20);
      for (int b = 0; b < burst; b++) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) op = OP_INC;
        else if (pick < 92) op = OP_LOOK;
        else if (pick < 94) op = OP_CLEAR;
        else op = OP_NONE;
        if ($urandom_range(0, 3) == 0)
          send_command(op, random_key(), random_key());
        else
          send_command(op, key_pool[$urandom_range(0, 15)], key_pool[$urandom_range(0, 15)]);
        n++;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      repeat (gap) @(posedge clk);
    end
    // Source table full: fill all 256 source slots, then one more.
    send_command(OP_CLEAR, '0, '0);
    for (int i = 0; i < SOURCE_SLOTS + 1; i++) send_command(OP_INC, random_key(), dst_a);

    repeat (20) @(posedge clk);
    if (edge_board.errors == 0 && edge_board.pending_results.size() == 0)
      $display("tb_edge_frequency_hash_map: done, clean");
    else
      $display("tb_edge_frequency_hash_map: done, errors");
    $finish;
  end

  // Watchdog: generous fixed time well above the slowest correct run.
  initial begin
    #100ms;
    $display("tb_edge_frequency_hash_map: done, errors");
    $finish;
  end
endmodule
